// File: src/dlcc_pkg.sv
// ----------------------------------------------------------------------------
// dlcc_pkg
// Types, register indexes and sequencer codes of the dual RGB LED controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dlcc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_TAP_WINDOW   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENC_STEP     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BOOST_GAIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_COEFF = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RAINBOW_SPD  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_FLOOR  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_KNOB_SCALE   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_LED2_OFFSET  = 3'd7;

    localparam logic [1:0] HUE_INDEP    = 2'd0;
    localparam logic [1:0] HUE_MIRROR   = 2'd1;
    localparam logic [1:0] HUE_COMPL    = 2'd2;
    localparam logic [1:0] HUE_SPECTRUM = 2'd3;

    typedef struct packed {
        logic signed [4:0] encoder_steps;
        logic              encoder_press_edge;
        logic              button_one_edge;
        logic              button_two_edge;
        logic              button_one_held;
        logic              button_two_held;
        logic [15:0]       knob_one;
        logic [15:0]       knob_two;
        logic [31:0]       time_ms;
    } in_t;

    typedef struct packed {
        logic [15:0] first_red;
        logic [15:0] first_green;
        logic [15:0] first_blue;
        logic [15:0] second_red;
        logic [15:0] second_green;
        logic [15:0] second_blue;
        logic [1:0]  color_mode;
    } out_t;

    typedef struct packed {
        logic [15:0] tap_window_ms;
        logic [15:0] encoder_step;
        logic [16:0] boost_gain;
        logic [15:0] smoothing_coeff;
        logic [23:0] rainbow_speed;
        logic [15:0] speed_floor;
        logic [15:0] knob_phase_scale;
        logic [15:0] second_led_phase_offset;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RAINBOW, ST_KNOB1, ST_KNOB2, ST_HUE, ST_TGT1, ST_SMO1,
        ST_TGT2, ST_SMO2, ST_COL1, ST_COL2, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_RAINBOW, OP_KNOB1, OP_KNOB2, OP_HUE, OP_TGT1, OP_SMO1,
        OP_TGT2, OP_SMO2, OP_COL1, OP_COL2
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
        logic out_load;
    } cmd_t;

endpackage

`default_nettype wire

// File: src/dlcc_cfg.sv
// ----------------------------------------------------------------------------
// dlcc_cfg
// Configuration register file written through its own valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dlcc_cfg
    import dlcc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tap_window_ms           <= 16'd300;
            cfg_reg.encoder_step            <= 16'd1311;
            cfg_reg.boost_gain              <= 17'd98304;
            cfg_reg.smoothing_coeff         <= 16'd655;
            cfg_reg.rainbow_speed           <= 24'd2147484;
            cfg_reg.speed_floor             <= 16'd6554;
            cfg_reg.knob_phase_scale        <= 16'd19661;
            cfg_reg.second_led_phase_offset <= 16'd13107;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TAP_WINDOW:   cfg_reg.tap_window_ms           <= cfg_data[15:0];
                REG_ENC_STEP:     cfg_reg.encoder_step            <= cfg_data[15:0];
                REG_BOOST_GAIN:   cfg_reg.boost_gain              <= cfg_data[16:0];
                REG_SMOOTH_COEFF: cfg_reg.smoothing_coeff         <= cfg_data[15:0];
                REG_RAINBOW_SPD:  cfg_reg.rainbow_speed           <= cfg_data[23:0];
                REG_SPEED_FLOOR:  cfg_reg.speed_floor             <= cfg_data[15:0];
                REG_KNOB_SCALE:   cfg_reg.knob_phase_scale        <= cfg_data[15:0];
                REG_LED2_OFFSET:  cfg_reg.second_led_phase_offset <= cfg_data[15:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/dlcc_ctrl.sv
// ----------------------------------------------------------------------------
// dlcc_ctrl
// Sequencer stepping the shared multiplier and owning the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module dlcc_ctrl
    import dlcc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output cmd_t      cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_RAINBOW;
            ST_RAINBOW: state_next = ST_KNOB1;
            ST_KNOB1:   state_next = ST_KNOB2;
            ST_KNOB2:   state_next = ST_HUE;
            ST_HUE:     state_next = ST_TGT1;
            ST_TGT1:    state_next = ST_SMO1;
            ST_SMO1:    state_next = ST_TGT2;
            ST_TGT2:    state_next = ST_SMO2;
            ST_SMO2:    state_next = ST_COL1;
            ST_COL1:    state_next = ST_COL2;
            ST_COL2:    state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.load     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE:    cmd.load = s_valid;
            ST_RAINBOW: cmd.op = OP_RAINBOW;
            ST_KNOB1:   cmd.op = OP_KNOB1;
            ST_KNOB2:   cmd.op = OP_KNOB2;
            ST_HUE:     cmd.op = OP_HUE;
            ST_TGT1:    cmd.op = OP_TGT1;
            ST_SMO1:    cmd.op = OP_SMO1;
            ST_TGT2:    cmd.op = OP_TGT2;
            ST_SMO2:    cmd.op = OP_SMO2;
            ST_COL1:    cmd.op = OP_COL1;
            ST_COL2:    cmd.op = OP_COL2;
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// File: src/dlcc_datapath.sv
// ----------------------------------------------------------------------------
// dlcc_datapath
// Tick state, shared multiplier, smoothing and HSV to RGB conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module dlcc_datapath
    import dlcc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  cmd_t      cmd,
    input  cfg_t      cfg,
    input  in_t       s_data,
    output out_t      m_data
);

    in_t         in_reg;
    logic [1:0]  mode_reg, mode_next;
    logic [16:0] mb_reg, mb_next;
    logic [31:0] phase_reg;
    logic        latch1_reg, latch1_next, latch2_reg, latch2_next;
    logic [31:0] tap1_reg, tap1_next, tap2_reg, tap2_next;
    logic [17:0] sm1_reg, sm2_reg;
    logic [15:0] off1_reg, off2_reg;
    logic [16:0] tgt_reg;
    logic [2:0]  sec1_reg, sec2_reg;
    logic [15:0] f1_reg, f2_reg;
    logic [16:0] t1_reg, t2_reg;
    out_t        out_reg;

    logic [23:0] mul_a;
    logic [17:0] mul_b;
    logic [41:0] prod;
    logic signed [21:0] bsum;
    logic [16:0] g1, g2, v1, v2;
    logic [16:0] ksum;
    logic [31:0] h1, h2;
    logic [34:0] h6a, h6b;
    logic [17:0] sm_cur, diff;
    logic        up;
    logic [34:0] rnd;
    logic [17:0] sm_new;

    function automatic logic [15:0] sat16(input logic [16:0] x);
        sat16 = x[16] ? 16'hFFFF : x[15:0];
    endfunction

    function automatic logic [47:0] hsv(input logic [2:0] sec, input logic [16:0] v,
                                        input logic [16:0] t);
        logic [16:0] q;
        logic [16:0] r, g, b;
        q = v - t;
        case (sec)
            3'd0:    begin r = v;     g = t;     b = 17'd0; end
            3'd1:    begin r = q;     g = v;     b = 17'd0; end
            3'd2:    begin r = 17'd0; g = v;     b = t;     end
            3'd3:    begin r = 17'd0; g = q;     b = v;     end
            3'd4:    begin r = t;     g = 17'd0; b = v;     end
            default: begin r = v;     g = 17'd0; b = q;     end
        endcase
        hsv = {sat16(r), sat16(g), sat16(b)};
    endfunction

    assign g1 = (in_reg.button_one_held || latch1_reg) ? cfg.boost_gain : 17'd65536;
    assign g2 = (in_reg.button_two_held || latch2_reg) ? cfg.boost_gain : 17'd65536;
    assign v1 = sm1_reg > 18'd65536 ? 17'd65536 : sm1_reg[16:0];
    assign v2 = sm2_reg > 18'd65536 ? 17'd65536 : sm2_reg[16:0];

    // first beat: brightness, mode and taps
    always_comb begin
        bsum = 22'(signed'({1'b0, mb_reg}))
             + 22'(s_data.encoder_steps) * 22'(signed'({1'b0, cfg.encoder_step}));
        if (bsum < 0)
            mb_next = 17'd0;
        else if (bsum > 22'sd65536)
            mb_next = 17'd65536;
        else
            mb_next = bsum[16:0];
        mode_next   = s_data.encoder_press_edge ? mode_reg + 2'd1 : mode_reg;
        latch1_next = latch1_reg;
        tap1_next   = tap1_reg;
        latch2_next = latch2_reg;
        tap2_next   = tap2_reg;
        if (s_data.button_one_edge) begin
            if ((s_data.time_ms - tap1_reg) < {16'd0, cfg.tap_window_ms})
                latch1_next = !latch1_reg;
            tap1_next = s_data.time_ms;
        end
        if (s_data.button_two_edge) begin
            if ((s_data.time_ms - tap2_reg) < {16'd0, cfg.tap_window_ms})
                latch2_next = !latch2_reg;
            tap2_next = s_data.time_ms;
        end
    end

    always_comb begin
        sm_cur = (cmd.op == OP_SMO2) ? sm2_reg : sm1_reg;
        up     = {1'b0, tgt_reg} >= sm_cur;
        diff   = up ? {1'b0, tgt_reg} - sm_cur : sm_cur - {1'b0, tgt_reg};
    end

    always_comb begin
        mul_a = 24'd0;
        mul_b = 18'd0;
        case (cmd.op)
            OP_RAINBOW: begin
                mul_a = cfg.rainbow_speed;
                mul_b = {1'b0, mb_reg} + {2'b0, cfg.speed_floor};
            end
            OP_KNOB1: begin
                mul_a = {8'd0, cfg.knob_phase_scale};
                mul_b = {2'd0, in_reg.knob_one};
            end
            OP_KNOB2: begin
                mul_a = {8'd0, cfg.knob_phase_scale};
                mul_b = {2'd0, in_reg.knob_two};
            end
            OP_TGT1: begin
                mul_a = {7'd0, g1};
                mul_b = {1'b0, mb_reg};
            end
            OP_TGT2: begin
                mul_a = {7'd0, g2};
                mul_b = {1'b0, mb_reg};
            end
            OP_SMO1, OP_SMO2: begin
                mul_a = {8'd0, cfg.smoothing_coeff};
                mul_b = diff;
            end
            OP_COL1: begin
                mul_a = {8'd0, f1_reg};
                mul_b = {1'b0, v1};
            end
            OP_COL2: begin
                mul_a = {8'd0, f2_reg};
                mul_b = {1'b0, v2};
            end
            default: begin
                mul_a = 24'd0;
                mul_b = 18'd0;
            end
        endcase
    end

    assign prod   = {18'd0, mul_a} * {24'd0, mul_b};
    assign rnd    = {1'b0, prod[33:0]} + 35'd32768;
    assign sm_new = up ? sm_cur + rnd[33:16] : sm_cur - rnd[33:16];

    always_comb begin
        ksum = {1'b0, in_reg.knob_one} + {1'b0, in_reg.knob_two};
        case (mode_reg)
            HUE_INDEP: begin
                h1 = {in_reg.knob_one, 16'd0};
                h2 = {in_reg.knob_two, 16'd0};
            end
            HUE_MIRROR: begin
                h1 = {ksum[16:1], 16'd0};
                h2 = h1;
            end
            HUE_COMPL: begin
                h1 = {in_reg.knob_one, 16'd0};
                h2 = h1 + 32'h8000_0000;
            end
            default: begin
                h1 = phase_reg + {off1_reg, 16'd0};
                h2 = phase_reg + {off2_reg, 16'd0} + {cfg.second_led_phase_offset, 16'd0};
            end
        endcase
        h6a = {1'b0, h1, 2'b0} + {2'b0, h1, 1'b0};
        h6b = {1'b0, h2, 2'b0} + {2'b0, h2, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= HUE_INDEP;
            mb_reg     <= 17'd32768;
            phase_reg  <= 32'd0;
            latch1_reg <= 1'b0;
            latch2_reg <= 1'b0;
            tap1_reg   <= 32'd0;
            tap2_reg   <= 32'd0;
            sm1_reg    <= 18'd32768;
            sm2_reg    <= 18'd32768;
        end else begin
            if (cmd.load) begin
                mode_reg   <= mode_next;
                mb_reg     <= mb_next;
                latch1_reg <= latch1_next;
                latch2_reg <= latch2_next;
                tap1_reg   <= tap1_next;
                tap2_reg   <= tap2_next;
            end
            if (cmd.op == OP_RAINBOW && mode_reg == HUE_SPECTRUM)
                phase_reg <= phase_reg + {6'd0, prod[41:16]};
            if (cmd.op == OP_SMO1)
                sm1_reg <= sm_new;
            if (cmd.op == OP_SMO2)
                sm2_reg <= sm_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load)
            in_reg <= s_data;
        case (cmd.op)
            OP_KNOB1: off1_reg <= prod[31:16];
            OP_KNOB2: off2_reg <= prod[31:16];
            OP_HUE: begin
                sec1_reg <= h6a[34:32];
                f1_reg   <= h6a[31:16];
                sec2_reg <= h6b[34:32];
                f2_reg   <= h6b[31:16];
            end
            OP_TGT1, OP_TGT2: tgt_reg <= prod[32:16];
            OP_COL1: t1_reg <= prod[32:16];
            OP_COL2: t2_reg <= prod[32:16];
            default: tgt_reg <= tgt_reg;
        endcase
        if (cmd.out_load) begin
            {out_reg.first_red, out_reg.first_green, out_reg.first_blue}
                <= hsv(sec1_reg, v1, t1_reg);
            {out_reg.second_red, out_reg.second_green, out_reg.second_blue}
                <= hsv(sec2_reg, v2, t2_reg);
            out_reg.color_mode <= mode_reg;
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

// File: src/dual_rgb_led_color_controller.sv
// ----------------------------------------------------------------------------
// dual_rgb_led_color_controller
// Brightness, boost, hue modes and HSV to RGB for two LEDs, one beat per tick.
//
//   channel   ports              beat
//   input     s_valid/s_ready    one control tick (in_t)
//   result    m_valid/m_ready    six colors and the mode (out_t)
//   config    cfg_valid/ready    register index and data
//
// After acceptance in the idle state, one shared multiplier runs ten
// sequenced steps, then the result register loads. s_ready is high only
// while the sequencer is idle; the next tick is taken while the previous
// result still waits. A stalled result holds the sequencer in its last
// step. Synchronous active-low reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_rgb_led_color_controller
    import dlcc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  in_t                         s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_t                        m_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;
    cmd_t cmd;

    dlcc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dlcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    dlcc_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .cfg     (cfg),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
